[sv/fsla_pkg.sv]
// ----------------------------------------------------------------------------
// fsla_pkg
// Shared types and constants of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsla_pkg;

	localparam int MAX_SLOTS      = 4096;
	localparam int SLOT_IDX_W     = 12;
	localparam int SLOT_CNT_W     = 13;
	localparam int POOL_LOG2      = 22;
	localparam int OFFSET_W       = 22;
	localparam int CFG_W          = 24;
	localparam int SIZE_W         = 21;
	localparam int SHIFT_W        = 5;
	localparam int CNT_W          = 32;
	localparam int MIN_SLOT_BYTES = 1024;
	localparam int MAX_SLOT_BYTES = 1024 * 1024;
	localparam int MIN_SHIFT      = 10;

	localparam logic       FUNC_ALLOC = 1'b0;
	localparam logic       FUNC_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_SLOTS  = 2'd1;
	localparam logic [1:0] STATUS_NOT_TAKEN = 2'd2;
	localparam logic [1:0] STATUS_RANGE     = 2'd3;

	typedef struct packed {
		logic                  func;
		logic [SLOT_IDX_W-1:0] slot_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [SLOT_IDX_W-1:0] granted_slot;
		logic [OFFSET_W-1:0]   slot_offset;
		logic [CNT_W-1:0]      alloc_total;
		logic [CNT_W-1:0]      free_total;
	} out_item_t;

	typedef struct packed {
		logic                  clear_start;
		logic                  rd_en;
		logic [SLOT_IDX_W-1:0] rd_addr;
		logic                  taken_we;
		logic [SLOT_IDX_W-1:0] taken_waddr;
		logic                  taken_wdata;
		logic                  link_we;
		logic [SLOT_IDX_W-1:0] link_waddr;
		logic [SLOT_IDX_W-1:0] link_wdata;
	} store_req_t;

	typedef struct packed {
		logic                  clear_busy;
		logic                  taken_rd;
		logic [SLOT_IDX_W-1:0] link_rd;
	} store_rsp_t;

	// Slots in the pool for a slot size of 2**shift.
	function automatic logic [SLOT_CNT_W-1:0] slot_count_of(input logic [SHIFT_W-1:0] shift);
		logic [SHIFT_W-1:0] cnt_log2;
		cnt_log2 = SHIFT_W'(POOL_LOG2) - shift;
		return SLOT_CNT_W'(1) << cnt_log2;
	endfunction

endpackage

[sv/fixed_slot_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Allocates and frees fixed-size slots of one pool through a LIFO free list.
// ----------------------------------------------------------------------------
// The accept cycle of a request reads the slot store (link
// of the free-list head, or the taken flag of the slot being freed) into its
// registered read port, and the execute state, once the result register is
// free, resolves the request, writes the store and loads the result register.
// After reset and after every write of the slot size register the block runs
// a clearing pass over the 4096 taken flags, one per cycle, and accepts no
// request while it runs; the slot-size search runs under that pass.
module fixed_slot_free_list_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fsla_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  fsla_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output fsla_pkg::out_item_t          out_item
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                              state_q;
	fsla_pkg::in_item_t                op_q;
	logic [fsla_pkg::SLOT_IDX_W-1:0]   head_q;
	logic                              nonempty_q;
	logic [fsla_pkg::SLOT_CNT_W-1:0]   untouched_q;
	logic [fsla_pkg::CNT_W-1:0]        alloc_cnt_q;
	logic [fsla_pkg::CNT_W-1:0]        free_cnt_q;
	logic                              out_valid_q;
	fsla_pkg::out_item_t               out_q;

	logic [fsla_pkg::SHIFT_W-1:0]      shift;
	logic                              size_busy;
	logic [fsla_pkg::SLOT_CNT_W-1:0]   slot_count;
	fsla_pkg::store_req_t              st_req;
	fsla_pkg::store_rsp_t              st_rsp;

	logic                              accept;
	logic                              exec_go;
	logic                              from_list;
	logic                              from_fresh;
	logic [fsla_pkg::SLOT_IDX_W-1:0]   slot;
	logic                              idx_ok;
	fsla_pkg::out_item_t               res;

	fsla_size_unit u_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.shift     (shift),
		.busy      (size_busy)
	);

	fsla_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rsp    (st_rsp)
	);

	assign slot_count = fsla_pkg::slot_count_of(shift);
	assign in_stall   = (state_q != ST_IDLE) || st_rsp.clear_busy || size_busy;
	assign accept     = in_valid && !in_stall;
	assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	assign from_list  = nonempty_q && ({1'b0, head_q} < slot_count);
	assign from_fresh = !from_list && (untouched_q != '0);
	assign idx_ok     = {1'b0, op_q.slot_index} < slot_count;

	always_comb begin
		if (from_list) begin
			slot = head_q;
		end else begin
			slot = fsla_pkg::SLOT_IDX_W'(untouched_q - fsla_pkg::SLOT_CNT_W'(1));
		end
	end

	// Resolve the request and build the store read and writes.
	always_comb begin
		st_req             = '0;
		st_req.clear_start = cfg_we;
		st_req.rd_en       = accept;
		st_req.rd_addr     = (in_item.func == fsla_pkg::FUNC_FREE) ? in_item.slot_index : head_q;

		res              = '0;
		res.alloc_total  = alloc_cnt_q;
		res.free_total   = free_cnt_q + fsla_pkg::CNT_W'(1);

		if (op_q.func == fsla_pkg::FUNC_ALLOC) begin
			res.free_total = free_cnt_q;
			if (from_list || from_fresh) begin
				res.status       = fsla_pkg::STATUS_OK;
				res.granted_slot = slot;
				res.slot_offset  = fsla_pkg::OFFSET_W'(slot) << shift;
				res.alloc_total  = alloc_cnt_q + fsla_pkg::CNT_W'(1);
				st_req.taken_we    = exec_go;
				st_req.taken_waddr = slot;
				st_req.taken_wdata = 1'b1;
			end else begin
				res.status = fsla_pkg::STATUS_NO_SLOTS;
			end
		end else if (!idx_ok) begin
			res.status = fsla_pkg::STATUS_RANGE;
		end else if (st_rsp.taken_rd) begin
			res.status         = fsla_pkg::STATUS_OK;
			st_req.taken_we    = exec_go;
			st_req.taken_waddr = op_q.slot_index;
			st_req.taken_wdata = 1'b0;
			// the tail of the list links to itself
			st_req.link_we     = exec_go;
			st_req.link_waddr  = op_q.slot_index;
			st_req.link_wdata  = nonempty_q ? head_q : op_q.slot_index;
		end else begin
			res.status = fsla_pkg::STATUS_NOT_TAKEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			nonempty_q  <= 1'b0;
			untouched_q <= fsla_pkg::SLOT_CNT_W'(fsla_pkg::MAX_SLOTS);
			alloc_cnt_q <= '0;
			free_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				head_q     <= '0;
				nonempty_q <= 1'b0;
			end
			// track the slot count while the pool is being initialized
			if (st_rsp.clear_busy) begin
				untouched_q <= slot_count;
			end
			if (accept) begin
				state_q <= ST_EXEC;
			end
			if (exec_go) begin
				state_q     <= ST_IDLE;
				out_valid_q <= 1'b1;
				alloc_cnt_q <= res.alloc_total;
				free_cnt_q  <= res.free_total;
				if (op_q.func == fsla_pkg::FUNC_ALLOC) begin
					if (from_list) begin
						if (st_rsp.link_rd == head_q) begin
							nonempty_q <= 1'b0;
						end else begin
							head_q <= st_rsp.link_rd;
						end
					end else if (from_fresh) begin
						untouched_q <= untouched_q - fsla_pkg::SLOT_CNT_W'(1);
					end
				end else if (idx_ok && st_rsp.taken_rd) begin
					head_q     <= op_q.slot_index;
					nonempty_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= in_item;
		end
		if (exec_go) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_head_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(!st_rsp.clear_busy && nonempty_q) |-> ({1'b0, head_q} < slot_count))
		else $error("free-list head outside the pool");

	a_untouched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!st_rsp.clear_busy |-> (untouched_q <= slot_count))
		else $error("untouched slot count exceeds pool size");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without a resolved request");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_rsp.clear_busy |=> (state_q == ST_IDLE))
		else $error("request taken during clearing pass");

	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == fsla_pkg::STATUS_OK) |->
		({1'b0, out_q.granted_slot} < slot_count))
		else $error("granted slot outside the pool");

endmodule

[sv/fsla_size_unit.sv]
// ----------------------------------------------------------------------------
// fsla_size_unit
// Clamps the requested slot size and rounds it up to a power of two with one
// shared compare-and-shift step per cycle.
// ----------------------------------------------------------------------------
module fsla_size_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsla_pkg::CFG_W-1:0]      cfg_wdata,
	output logic [fsla_pkg::SHIFT_W-1:0]    shift,
	output logic                            busy
);

	logic [fsla_pkg::SIZE_W-1:0]  req_q;
	logic [fsla_pkg::SIZE_W-1:0]  size_q;
	logic [fsla_pkg::SHIFT_W-1:0] shift_q;
	logic                         busy_q;
	logic [fsla_pkg::SIZE_W-1:0]  clamped;

	always_comb begin
		if (cfg_wdata > fsla_pkg::CFG_W'(fsla_pkg::MAX_SLOT_BYTES)) begin
			clamped = fsla_pkg::SIZE_W'(fsla_pkg::MAX_SLOT_BYTES);
		end else if (cfg_wdata < fsla_pkg::CFG_W'(fsla_pkg::MIN_SLOT_BYTES)) begin
			clamped = fsla_pkg::SIZE_W'(fsla_pkg::MIN_SLOT_BYTES);
		end else begin
			clamped = cfg_wdata[fsla_pkg::SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= fsla_pkg::SIZE_W'(fsla_pkg::MIN_SLOT_BYTES);
			size_q  <= fsla_pkg::SIZE_W'(fsla_pkg::MIN_SLOT_BYTES);
			shift_q <= fsla_pkg::SHIFT_W'(fsla_pkg::MIN_SHIFT);
			busy_q  <= 1'b0;
		end else if (cfg_we) begin
			req_q   <= clamped;
			size_q  <= fsla_pkg::SIZE_W'(fsla_pkg::MIN_SLOT_BYTES);
			shift_q <= fsla_pkg::SHIFT_W'(fsla_pkg::MIN_SHIFT);
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			// double until the size covers the request
			if (size_q < req_q) begin
				size_q  <= size_q << 1;
				shift_q <= shift_q + fsla_pkg::SHIFT_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign shift = shift_q;
	assign busy  = busy_q;

endmodule

[sv/fsla_slot_store.sv]
// ----------------------------------------------------------------------------
// fsla_slot_store
// Per-slot taken flags and free-list links, with registered reads and a
// clearing pass over the taken flags.
// ----------------------------------------------------------------------------
module fsla_slot_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fsla_pkg::store_req_t    req,
	output fsla_pkg::store_rsp_t    rsp
);

	logic                              taken_mem [fsla_pkg::MAX_SLOTS];
	logic [fsla_pkg::SLOT_IDX_W-1:0]   link_mem  [fsla_pkg::MAX_SLOTS];
	logic                              taken_rd_q;
	logic [fsla_pkg::SLOT_IDX_W-1:0]   link_rd_q;
	logic [fsla_pkg::SLOT_IDX_W-1:0]   clr_idx_q;
	logic                              clr_busy_q;
	logic                              t_we;
	logic [fsla_pkg::SLOT_IDX_W-1:0]   t_addr;
	logic                              t_data;

	// The clearing pass owns the taken-flag write port while it runs.
	always_comb begin
		if (clr_busy_q) begin
			t_we   = 1'b1;
			t_addr = clr_idx_q;
			t_data = 1'b0;
		end else begin
			t_we   = req.taken_we;
			t_addr = req.taken_waddr;
			t_data = req.taken_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (req.clear_start) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == fsla_pkg::SLOT_IDX_W'(fsla_pkg::MAX_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + fsla_pkg::SLOT_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			taken_mem[t_addr] <= t_data;
		end
		if (req.link_we) begin
			link_mem[req.link_waddr] <= req.link_wdata;
		end
		if (req.rd_en) begin
			taken_rd_q <= taken_mem[req.rd_addr];
			link_rd_q  <= link_mem[req.rd_addr];
		end
	end

	assign rsp.clear_busy = clr_busy_q;
	assign rsp.taken_rd   = taken_rd_q;
	assign rsp.link_rd    = link_rd_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-slot allocator: a directed table of
// allocate/free requests across slot-size settings, then random phases, most
// with sender and receiver idling, every result checked against an in-bench model or the table.
// ----------------------------------------------------------------------------
module tb_top;
	import fsla_pkg::*;

	localparam int RUN_LIMIT   = 400000;
	localparam int DRAIN_GAP   = 4;
	localparam int LONG_HOLD   = 80;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 105;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_W-1:0]      size;
		in_item_t              op;
		logic                  typed;
		logic [1:0]            status;
		logic [SLOT_IDX_W-1:0] slot;
		logic [OFFSET_W-1:0]   offset;
	} step_row_t;

	localparam int STEPS = 27;
	localparam step_row_t STEP_TABLE [STEPS] = '{
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd0}, 1'b1, STATUS_NOT_TAKEN, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd4095, 22'd4193280},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd4094, 22'd4192256},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd4095}, 1'b1, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd4095}, 1'b1, STATUS_NOT_TAKEN, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd4095, 22'd4193280},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd4094}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd4095}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'hFFF}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b1, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd4095, 22'd4193280},
		'{1'b1, 24'hFFFFFF, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd4}, 1'b1, STATUS_RANGE, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd4095}, 1'b1, STATUS_RANGE, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd3, 22'd3145728},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_NO_SLOTS, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b1, 24'd3000, '{FUNC_ALLOC, 12'd0}, 1'b0, STATUS_OK, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_ALLOC, 12'd0}, 1'b1, STATUS_OK, 12'd1023, 22'd4190208},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd1024}, 1'b1, STATUS_RANGE, 12'd0, 22'd0},
		'{1'b0, 24'd0, '{FUNC_FREE, 12'd1023}, 1'b0, STATUS_OK, 12'd0, 22'd0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_item = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_item;

	fixed_slot_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// Allocator model state
	logic [SLOT_IDX_W-1:0] link_mem [MAX_SLOTS];
	logic                  slot_held [MAX_SLOTS];
	logic [SLOT_IDX_W-1:0] list_head;
	logic                  list_live;
	logic [SLOT_CNT_W-1:0] fresh_left;
	logic [SLOT_CNT_W-1:0] pool_slots;
	int                    pool_shift;
	logic [CNT_W-1:0]      grant_count;
	logic [CNT_W-1:0]      release_count;
	logic [SLOT_IDX_W-1:0] held_q [$];

	out_item_t   reply_q [$];
	out_item_t   want;
	int          mismatches = 0;
	int unsigned cycle_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_asks = 0;
	int          hold_done = 0;
	int          hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= RUN_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic void setup_pool(input logic [CFG_W-1:0] req_bytes);
		logic [CFG_W-1:0] bytes;
		bytes = req_bytes;
		if (bytes > MAX_SLOT_BYTES) bytes = MAX_SLOT_BYTES;
		if (bytes < MIN_SLOT_BYTES) bytes = MIN_SLOT_BYTES;
		pool_shift = MIN_SHIFT;
		while ((CFG_W'(1) << pool_shift) < bytes) pool_shift++;
		pool_slots = SLOT_CNT_W'(1) << (POOL_LOG2 - pool_shift);
		for (int s = 0; s < MAX_SLOTS; s++) slot_held[s] = 1'b0;
		list_head = '0;
		list_live = 1'b0;
		fresh_left = pool_slots;
		held_q.delete();
	endfunction

	// Advance the model by one request and return the result it owes.
	function automatic out_item_t predict_reply(input in_item_t req);
		out_item_t             r;
		logic [SLOT_IDX_W-1:0] slot;
		logic                  got;
		int                    hits [$];
		r = '0;
		slot = '0;
		got = 1'b1;
		if (req.func == FUNC_ALLOC) begin
			if (list_live && list_head < pool_slots) begin
				slot = list_head;
				// a self-link marks the tail of the freed list
				if (link_mem[slot] == slot) list_live = 1'b0;
				else list_head = link_mem[slot];
			end else if (fresh_left != 0) begin
				fresh_left = fresh_left - 1'b1;
				slot = fresh_left[SLOT_IDX_W-1:0];
			end else begin
				got = 1'b0;
			end
			if (got) begin
				slot_held[slot] = 1'b1;
				grant_count = grant_count + 1'b1;
				r.granted_slot = slot;
				r.slot_offset = OFFSET_W'(slot) << pool_shift;
				held_q.push_back(slot);
			end else begin
				r.status = STATUS_NO_SLOTS;
			end
		end else begin
			release_count = release_count + 1'b1;
			if (SLOT_CNT_W'(req.slot_index) >= pool_slots) begin
				r.status = STATUS_RANGE;
			end else if (slot_held[req.slot_index]) begin
				slot_held[req.slot_index] = 1'b0;
				link_mem[req.slot_index] = list_live ? list_head : req.slot_index;
				list_head = req.slot_index;
				list_live = 1'b1;
				hits = held_q.find_first_index(x) with (x == req.slot_index);
				if (hits.size() != 0) held_q.delete(hits[0]);
			end else begin
				r.status = STATUS_NOT_TAKEN;
			end
		end
		r.alloc_total = grant_count;
		r.free_total = release_count;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_v);
		$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_v);
		mismatches++;
	endtask

	// Drop valid, wait for every owed result, then let the pipeline go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_slot_size(input logic [CFG_W-1:0] bytes);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= bytes;
		@(posedge clk);
		cfg_we <= 1'b0;
		setup_pool(bytes);
	endtask

	task automatic transfer_item(input in_item_t req, input logic typed,
			input logic [1:0] st, input logic [SLOT_IDX_W-1:0] sl,
			input logic [OFFSET_W-1:0] off);
		out_item_t exp_r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		exp_r = predict_reply(req);
		if (typed) begin
			exp_r.status = st;
			exp_r.granted_slot = sl;
			exp_r.slot_offset = off;
		end
		reply_q.push_back(exp_r);
	endtask

	// Receiver: random stall, or a long hold-off when the sender asks for one.
	always @(posedge clk) begin
		if (hold_left == 0 && hold_asks != hold_done) begin
			hold_done = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				report_mismatch("unexpected result", 32'(out_item.status), 0);
			end else begin
				want = reply_q.pop_front();
				if (out_item.status !== want.status)
					report_mismatch("status", 32'(out_item.status), 32'(want.status));
				if (out_item.granted_slot !== want.granted_slot)
					report_mismatch("granted_slot", 32'(out_item.granted_slot),
						32'(want.granted_slot));
				if (out_item.slot_offset !== want.slot_offset)
					report_mismatch("slot_offset", 32'(out_item.slot_offset),
						32'(want.slot_offset));
				if (out_item.alloc_total !== want.alloc_total)
					report_mismatch("alloc_total", out_item.alloc_total, want.alloc_total);
				if (out_item.free_total !== want.free_total)
					report_mismatch("free_total", out_item.free_total, want.free_total);
			end
		end
	end

	initial begin
		in_item_t         req;
		logic [CFG_W-1:0] size;
		int               roll;
		grant_count = '0;
		release_count = '0;
		for (int s = 0; s < MAX_SLOTS; s++) link_mem[s] = '0;
		setup_pool(CFG_W'(MIN_SLOT_BYTES));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 28;
		recv_idle_pct = 65;
		foreach (STEP_TABLE[i]) begin
			if (STEP_TABLE[i].is_cfg)
				write_slot_size(STEP_TABLE[i].size);
			else
				transfer_item(STEP_TABLE[i].op, STEP_TABLE[i].typed, STEP_TABLE[i].status,
					STEP_TABLE[i].slot, STEP_TABLE[i].offset);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = (ph < 3) ? 28 : (ph < 6) ? 65 : 0;
			recv_idle_pct = (ph < 3) ? 65 : (ph < 6) ? 28 : 0;
			// favor large slots so that small pools run dry often
			case ($urandom_range(5))
				0: size = '0;
				1: size = '1;
				2: size = CFG_W'(MAX_SLOT_BYTES);
				3: size = CFG_W'($urandom_range(MAX_SLOT_BYTES - 1, MIN_SLOT_BYTES + 1));
				4: size = CFG_W'($urandom_range(MAX_SLOT_BYTES, MAX_SLOT_BYTES / 4));
				default: size = CFG_W'($urandom_range(24'hFFFFFF));
			endcase
			write_slot_size(size);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 7 && n == 30) hold_asks++;
				if (ph == 7 && n == 70) settle();
				roll = $urandom_range(99);
				req.func = FUNC_FREE;
				req.slot_index = SLOT_IDX_W'($urandom_range(MAX_SLOTS - 1));
				if (roll < 45)
					req.func = FUNC_ALLOC;
				else if (roll < 82 && held_q.size() != 0)
					req.slot_index = held_q[$urandom_range(held_q.size() - 1)];
				else if (roll < 92)
					req.slot_index = SLOT_IDX_W'($urandom_range(int'(pool_slots) - 1));
				transfer_item(req, 1'b0, STATUS_OK, '0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

[sim.f]
sv/fsla_pkg.sv
sv/fsla_size_unit.sv
sv/fsla_slot_store.sv
sv/fixed_slot_free_list_allocator.sv
dv/tb_top.sv
